FILE: src/lbm_d2q9_swe_collision_macros.svh
// Assertion macros shared by the collision kernel and its divider.
`ifndef LBM_D2Q9_SWE_COLLISION_MACROS_SVH
`define LBM_D2Q9_SWE_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lbm_swe_pkg.sv
// Types, constants and fixed-point helpers of the shallow-water collision kernel.
package lbm_swe_pkg;

    localparam int DW        = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int NDIR      = 9;
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 32;
    localparam int NPOST     = 13;

    localparam logic [CFG_W-1:0] RST_LATTICE_SPEED = 31'd65536;
    localparam logic [CFG_W-1:0] RST_RELAX_INVERSE = 31'd65536;
    localparam logic [CFG_W-1:0] RST_EQ_SCALE      = 31'd7282;

    localparam logic signed [DW-1:0] C_ONE     = 32'sd65536;
    localparam logic signed [DW-1:0] C_GH      = 32'sd963379;
    localparam logic signed [DW-1:0] C_1P5     = 32'sd98304;
    localparam logic signed [DW-1:0] C_3       = 32'sd196608;
    localparam logic signed [DW-1:0] C_4P5     = 32'sd294912;
    localparam logic signed [DW-1:0] C_QUARTER = 32'sd16384;
    localparam logic signed [DW-1:0] C_5       = 32'sd327680;
    localparam logic signed [DW-1:0] C_4       = 32'sd262144;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LATTICE_SPEED = 2'd0,
        CFG_RELAX_INVERSE = 2'd1,
        CFG_EQ_SCALE      = 2'd2
    } t_cfg_idx;

    // Base term used by each direction: ux3, uy3, d5, d6.
    localparam logic [1:0] S_IDX [NDIR] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1,
                                            2'd2, 2'd3, 2'd2, 2'd3};
    // Directions whose velocity term is negated.
    localparam logic V_NEG [NDIR] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                                      1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic                 cell_active;
        logic signed [DW-1:0] dist_rest;
        logic signed [DW-1:0] dist_east;
        logic signed [DW-1:0] dist_north;
        logic signed [DW-1:0] dist_west;
        logic signed [DW-1:0] dist_south;
        logic signed [DW-1:0] dist_northeast;
        logic signed [DW-1:0] dist_northwest;
        logic signed [DW-1:0] dist_southwest;
        logic signed [DW-1:0] dist_southeast;
    } t_in;

    typedef struct packed {
        logic signed [DW-1:0] post_rest;
        logic signed [DW-1:0] post_east;
        logic signed [DW-1:0] post_north;
        logic signed [DW-1:0] post_west;
        logic signed [DW-1:0] post_south;
        logic signed [DW-1:0] post_northeast;
        logic signed [DW-1:0] post_northwest;
        logic signed [DW-1:0] post_southwest;
        logic signed [DW-1:0] post_southeast;
        logic signed [DW-1:0] depth;
        logic signed [DW-1:0] vel_x;
        logic signed [DW-1:0] vel_y;
    } t_out;

    // Side data carried through the divider beside the x quotient.
    typedef struct packed {
        logic [NDIR-1:0][DW-1:0] f;
        logic [DW-1:0]           h;
        logic                    hz;
        logic                    negx;
    } t_tag;

    // Working set of the equilibrium and relaxation stages.
    typedef struct packed {
        logic [NDIR-1:0][DW-1:0] f;
        logic [DW-1:0]           h;
        logic [DW-1:0]           ux;
        logic [DW-1:0]           uy;
        logic [DW-1:0]           uxx;
        logic [DW-1:0]           uyy;
        logic [DW-1:0]           eux;
        logic [DW-1:0]           euy;
        logic [DW-1:0]           gh;
        logic [DW-1:0]           hk;
        logic [DW-1:0]           hkq;
        logic [DW-1:0]           gh5;
        logic [DW-1:0]           usqi;
        logic [DW-1:0]           usq;
        logic [DW-1:0]           usq4;
        logic [DW-1:0]           inner0;
        logic [DW-1:0]           t0;
        logic [DW-1:0]           r0;
        logic [3:0][DW-1:0]      sv;
        logic [3:0][DW-1:0]      a;
        logic [3:0][DW-1:0]      b;
        logic [3:0][DW-1:0]      sq;
        logic [NDIR-1:0][DW-1:0] gv;
        logic [NDIR-1:0][DW-1:0] x;
        logic [NDIR-1:0][DW-1:0] y;
        logic [NDIR-1:0][DW-1:0] feq;
        logic [NDIR-1:0][DW-1:0] diff;
        logic [NDIR-1:0][DW-1:0] m;
        logic [NDIR-1:0][DW-1:0] post;
    } t_work;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] qmul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(p >>> 16);
    endfunction

    function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [63:0] s;
        s = a + b;
        return sat32(s);
    endfunction

    function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [63:0] s;
        s = a - b;
        return sat32(s);
    endfunction

endpackage

FILE: src/lbm_swe_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module lbm_swe_div #(
    parameter int NUM_W = lbm_swe_pkg::DIV_NUM_W,
    parameter int DEN_W = lbm_swe_pkg::DIV_DEN_W,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    import lbm_swe_pkg::*;
    `include "lbm_d2q9_swe_collision_macros.svh"

    // The accumulator shifts dividend bits out at the top and quotient bits in.
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_acc [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];
    logic [NUM_W-1:0] r_vld;
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_acc [NUM_W];
    logic [DEN_W-1:0] n_den [NUM_W];
    logic [TAG_W-1:0] n_tag [NUM_W];
    logic [NUM_W-1:0] n_vld;

    always_comb begin
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] acc_in;
        logic [DEN_W:0]   sh;
        logic             ge;
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                rem_in   = '0;
                acc_in   = i_num;
                n_den[s] = i_den;
                n_tag[s] = i_tag;
                n_vld[s] = i_vld;
            end else begin
                rem_in   = r_rem[s-1];
                acc_in   = r_acc[s-1];
                n_den[s] = r_den[s-1];
                n_tag[s] = r_tag[s-1];
                n_vld[s] = r_vld[s-1];
            end
            sh       = {rem_in, acc_in[NUM_W-1]};
            ge       = (sh >= {1'b0, n_den[s]});
            n_rem[s] = ge ? DEN_W'(sh - {1'b0, n_den[s]}) : sh[DEN_W-1:0];
            n_acc[s] = {acc_in[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_den <= n_den;
        r_tag <= n_tag;
    end

    assign o_vld  = r_vld[NUM_W-1];
    assign o_quot = r_acc[NUM_W-1];
    assign o_tag  = r_tag[NUM_W-1];

    `LBM_ASSERT_IMP(a_div_latency, i_clk, i_rst_n, o_vld, $past(i_vld, NUM_W), "divider valid without matching input")
    `LBM_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, o_vld && (r_den[NUM_W-1] != '0), r_rem[NUM_W-1] < r_den[NUM_W-1], "divider remainder not below divisor")
    `LBM_ASSERT_NXT(a_div_step, i_clk, i_rst_n, r_vld[0], r_vld[1], "divider valid bit lost between stages")

endmodule

FILE: src/lbm_d2q9_swe_collision.sv
// Top level of the D2Q9 shallow-water lattice Boltzmann collision kernel.
//
// One cell enters per clock: a transfer takes place at every rising edge with start high
// and busy low, and busy is always low because the pipeline never stalls. Active cells
// come out as a one-cycle o_valid strobe with the nine post-collision distributions, depth
// and both velocities; inactive cells are dropped. The receiver cannot hold results off,
// so it must take every strobed transfer. The velocity divider resolves one of 62
// quotient bits per stage; four stages before it form depth, moments and the divider
// operands, and thirteen after it build the equilibria and the relaxation with at most
// one multiply per lane per stage. Configuration registers are written through a plain
// write port and must only be changed while no cell is in flight.
module lbm_d2q9_swe_collision (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lbm_swe_pkg::t_in                    i_in,
    input  logic                                i_cfg_we,
    input  logic [lbm_swe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbm_swe_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                                o_valid,
    output lbm_swe_pkg::t_out                   o_out
);
    import lbm_swe_pkg::*;
    `include "lbm_d2q9_swe_collision_macros.svh"

    localparam int LATENCY = 4 + DIV_NUM_W + NPOST;

    // Configuration registers.
    logic [CFG_W-1:0] r_e, r_ri, r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e  <= RST_LATTICE_SPEED;
            r_ri <= RST_RELAX_INVERSE;
            r_k  <= RST_EQ_SCALE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LATTICE_SPEED: r_e  <= i_cfg_data;
                CFG_RELAX_INVERSE: r_ri <= i_cfg_data;
                CFG_EQ_SCALE:      r_k  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] e_s, ri_s, k_s;
    assign e_s  = $signed({1'b0, r_e});
    assign ri_s = $signed({1'b0, r_ri});
    assign k_s  = $signed({1'b0, r_k});

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage A: partial sums of depth and both moments.
    logic [NDIR-1:0][DW-1:0] r_a_f;
    logic [2:0][35:0]        r_a_p;
    logic [1:0][35:0]        r_a_mx, r_a_my;
    logic                    r_a_v;
    logic [NDIR-1:0][DW-1:0] n_a_f;
    logic [2:0][35:0]        n_a_p;
    logic [1:0][35:0]        n_a_mx, n_a_my;

    always_comb begin
        logic signed [35:0] fe [NDIR];
        n_a_f = {i_in.dist_southeast, i_in.dist_southwest, i_in.dist_northwest,
                 i_in.dist_northeast, i_in.dist_south, i_in.dist_west,
                 i_in.dist_north, i_in.dist_east, i_in.dist_rest};
        for (int j = 0; j < NDIR; j++) begin
            fe[j] = $signed(n_a_f[j]);
        end
        n_a_p[0]  = fe[0] + fe[1] + fe[2];
        n_a_p[1]  = fe[3] + fe[4] + fe[5];
        n_a_p[2]  = fe[6] + fe[7] + fe[8];
        n_a_mx[0] = fe[1] - fe[3] + fe[5];
        n_a_mx[1] = fe[8] - fe[6] - fe[7];
        n_a_my[0] = fe[2] - fe[4] + fe[5];
        n_a_my[1] = fe[6] - fe[7] - fe[8];
    end

    // Stage B: saturated depth and moments.
    logic [NDIR-1:0][DW-1:0] r_b_f;
    logic signed [DW-1:0]    r_b_h, r_b_mx, r_b_my;
    logic                    r_b_v;
    logic signed [DW-1:0]    n_b_h, n_b_mx, n_b_my;

    always_comb begin
        logic signed [63:0] th, tx, ty;
        th = $signed(r_a_p[0]) + $signed(r_a_p[1]) + $signed(r_a_p[2]);
        tx = $signed(r_a_mx[0]) + $signed(r_a_mx[1]);
        ty = $signed(r_a_my[0]) + $signed(r_a_my[1]);
        n_b_h  = sat32(th);
        n_b_mx = sat32(tx);
        n_b_my = sat32(ty);
    end

    // Stage C: lattice speed times moments, the dividends of both velocities.
    logic [NDIR-1:0][DW-1:0] r_c_f;
    logic signed [DW-1:0]    r_c_h;
    logic signed [63:0]      r_c_nx, r_c_ny;
    logic                    r_c_v;
    logic signed [63:0]      n_c_nx, n_c_ny;

    assign n_c_nx = e_s * r_b_mx;
    assign n_c_ny = e_s * r_b_my;

    // Stage D: magnitudes and quotient signs for the dividers.
    logic [DIV_NUM_W-1:0] r_d_magx, r_d_magy;
    logic [DIV_DEN_W-1:0] r_d_den;
    t_tag                 r_d_tag;
    logic                 r_d_negy;
    logic                 r_d_v;
    logic [DIV_NUM_W-1:0] n_d_magx, n_d_magy;
    logic [DIV_DEN_W-1:0] n_d_den;
    t_tag                 n_d_tag;
    logic                 n_d_negy;

    always_comb begin
        logic signed [63:0] ax, ay;
        logic signed [32:0] ah;
        ax = r_c_nx[63] ? -r_c_nx : r_c_nx;
        ay = r_c_ny[63] ? -r_c_ny : r_c_ny;
        ah = r_c_h[DW-1] ? -$signed({r_c_h[DW-1], r_c_h}) : $signed({r_c_h[DW-1], r_c_h});
        n_d_magx     = ax[DIV_NUM_W-1:0];
        n_d_magy     = ay[DIV_NUM_W-1:0];
        n_d_den      = ah[DIV_DEN_W-1:0];
        n_d_tag.f    = r_c_f;
        n_d_tag.h    = r_c_h;
        n_d_tag.hz   = (r_c_h == '0);
        n_d_tag.negx = r_c_nx[63] ^ r_c_h[DW-1];
        n_d_negy     = r_c_ny[63] ^ r_c_h[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= accept && i_in.cell_active;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_f    <= n_a_f;
        r_a_p    <= n_a_p;
        r_a_mx   <= n_a_mx;
        r_a_my   <= n_a_my;
        r_b_f    <= r_a_f;
        r_b_h    <= n_b_h;
        r_b_mx   <= n_b_mx;
        r_b_my   <= n_b_my;
        r_c_f    <= r_b_f;
        r_c_h    <= r_b_h;
        r_c_nx   <= n_c_nx;
        r_c_ny   <= n_c_ny;
        r_d_magx <= n_d_magx;
        r_d_magy <= n_d_magy;
        r_d_den  <= n_d_den;
        r_d_tag  <= n_d_tag;
        r_d_negy <= n_d_negy;
    end

    // Velocity dividers; the x instance carries the cell data alongside.
    logic                 dx_vld, dy_vld;
    logic [DIV_NUM_W-1:0] dx_quot, dy_quot;
    logic [$bits(t_tag)-1:0] dx_tag;
    logic                 dy_neg;

    lbm_swe_div #(
        .NUM_W(DIV_NUM_W),
        .DEN_W(DIV_DEN_W),
        .TAG_W($bits(t_tag))
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_d_v),
        .i_num  (r_d_magx),
        .i_den  (r_d_den),
        .i_tag  (r_d_tag),
        .o_vld  (dx_vld),
        .o_quot (dx_quot),
        .o_tag  (dx_tag)
    );

    lbm_swe_div #(
        .NUM_W(DIV_NUM_W),
        .DEN_W(DIV_DEN_W),
        .TAG_W(1)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_d_v),
        .i_num  (r_d_magy),
        .i_den  (r_d_den),
        .i_tag  (r_d_negy),
        .o_vld  (dy_vld),
        .o_quot (dy_quot),
        .o_tag  (dy_neg)
    );

    // Equilibrium and relaxation stages. Each stage copies the working set and
    // fills in the terms that become available at that point.
    t_work           r_post [NPOST];
    t_work           n_post [NPOST];
    logic [NPOST-1:0] r_vp;
    t_tag            tg;

    assign tg = t_tag'(dx_tag);

    always_comb begin
        logic signed [63:0] qx, qy;
        logic signed [DW-1:0] vt;
        // Stage 0: signed, saturated velocities; zero depth forces zero.
        n_post[0]   = '0;
        n_post[0].f = tg.f;
        n_post[0].h = tg.h;
        qx = $signed({2'b00, dx_quot});
        qy = $signed({2'b00, dy_quot});
        if (tg.negx) qx = -qx;
        if (dy_neg)  qy = -qy;
        n_post[0].ux = tg.hz ? '0 : sat32(qx);
        n_post[0].uy = tg.hz ? '0 : sat32(qy);

        // Stage 1: velocity products, gravity term and depth scaling.
        n_post[1]     = r_post[0];
        n_post[1].uxx = qmul($signed(r_post[0].ux), $signed(r_post[0].ux));
        n_post[1].uyy = qmul($signed(r_post[0].uy), $signed(r_post[0].uy));
        n_post[1].eux = qmul(e_s, $signed(r_post[0].ux));
        n_post[1].euy = qmul(e_s, $signed(r_post[0].uy));
        n_post[1].gh  = qmul(C_GH, $signed(r_post[0].h));
        n_post[1].hk  = qmul($signed(r_post[0].h), k_s);

        // Stage 2.
        n_post[2]       = r_post[1];
        n_post[2].usqi  = sadd($signed(r_post[1].uxx), $signed(r_post[1].uyy));
        n_post[2].sv[0] = qmul(C_3, $signed(r_post[1].eux));
        n_post[2].sv[1] = qmul(C_3, $signed(r_post[1].euy));
        n_post[2].hkq   = qmul($signed(r_post[1].hk), C_QUARTER);
        n_post[2].gh5   = qmul(C_5, $signed(r_post[1].gh));

        // Stage 3: kinetic term and diagonal velocity sum and difference.
        n_post[3]       = r_post[2];
        n_post[3].usq   = qmul(C_1P5, $signed(r_post[2].usqi));
        n_post[3].sv[2] = sadd($signed(r_post[2].sv[1]), $signed(r_post[2].sv[0]));
        n_post[3].sv[3] = ssub($signed(r_post[2].sv[1]), $signed(r_post[2].sv[0]));

        // Stage 4.
        n_post[4]      = r_post[3];
        n_post[4].usq4 = qmul(C_4, $signed(r_post[3].usq));
        for (int i = 0; i < 4; i++) begin
            n_post[4].a[i] = qmul(C_4P5, $signed(r_post[3].sv[i]));
        end

        // Stage 5: squares of the base terms and gravity plus velocity terms.
        n_post[5]        = r_post[4];
        n_post[5].inner0 = sadd($signed(r_post[4].gh5), $signed(r_post[4].usq4));
        for (int i = 0; i < 4; i++) begin
            n_post[5].b[i] = qmul($signed(r_post[4].a[i]), $signed(r_post[4].sv[i]));
        end
        for (int j = 1; j < NDIR; j++) begin
            vt = $signed(r_post[4].sv[S_IDX[j]]);
            if (V_NEG[j]) vt = ssub('0, vt);
            n_post[5].gv[j] = sadd($signed(r_post[4].gh), vt);
        end

        // Stage 6.
        n_post[6]    = r_post[5];
        n_post[6].t0 = qmul(k_s, $signed(r_post[5].inner0));
        for (int i = 0; i < 4; i++) begin
            n_post[6].sq[i] = qmul($signed(r_post[5].b[i]), k_s);
        end

        // Stage 7.
        n_post[7]    = r_post[6];
        n_post[7].r0 = ssub(C_ONE, $signed(r_post[6].t0));
        for (int j = 1; j < NDIR; j++) begin
            n_post[7].x[j] = sadd($signed(r_post[6].gv[j]),
                                  $signed(r_post[6].sq[S_IDX[j]]));
        end

        // Stage 8: rest equilibrium and the bracket terms of the moving directions.
        n_post[8]        = r_post[7];
        n_post[8].feq[0] = qmul($signed(r_post[7].h), $signed(r_post[7].r0));
        for (int j = 1; j < NDIR; j++) begin
            n_post[8].y[j] = ssub($signed(r_post[7].x[j]), $signed(r_post[7].usq));
        end

        // Stage 9: moving equilibria; diagonals use the quarter weight.
        n_post[9] = r_post[8];
        for (int j = 1; j < NDIR; j++) begin
            n_post[9].feq[j] = qmul((j < 5) ? $signed(r_post[8].hk) : $signed(r_post[8].hkq),
                                    $signed(r_post[8].y[j]));
        end

        // Stages 10 to 12: relaxation toward equilibrium.
        n_post[10] = r_post[9];
        n_post[11] = r_post[10];
        n_post[12] = r_post[11];
        for (int j = 0; j < NDIR; j++) begin
            n_post[10].diff[j] = ssub($signed(r_post[9].f[j]), $signed(r_post[9].feq[j]));
            n_post[11].m[j]    = qmul($signed(r_post[10].diff[j]), ri_s);
            n_post[12].post[j] = ssub($signed(r_post[11].f[j]), $signed(r_post[11].m[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else begin
            r_vp <= {r_vp[NPOST-2:0], dx_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_post <= n_post;
    end

    assign o_valid              = r_vp[NPOST-1];
    assign o_out.post_rest      = r_post[NPOST-1].post[0];
    assign o_out.post_east      = r_post[NPOST-1].post[1];
    assign o_out.post_north     = r_post[NPOST-1].post[2];
    assign o_out.post_west      = r_post[NPOST-1].post[3];
    assign o_out.post_south     = r_post[NPOST-1].post[4];
    assign o_out.post_northeast = r_post[NPOST-1].post[5];
    assign o_out.post_northwest = r_post[NPOST-1].post[6];
    assign o_out.post_southwest = r_post[NPOST-1].post[7];
    assign o_out.post_southeast = r_post[NPOST-1].post[8];
    assign o_out.depth          = r_post[NPOST-1].h;
    assign o_out.vel_x          = r_post[NPOST-1].ux;
    assign o_out.vel_y          = r_post[NPOST-1].uy;

    `LBM_ASSERT_IMP(a_out_from_in, i_clk, i_rst_n, o_valid, $past(start && !busy && i_in.cell_active, LATENCY), "result without an accepted active cell")
    `LBM_ASSERT_IMP(a_zero_depth, i_clk, i_rst_n, o_valid && (o_out.depth == '0), (o_out.vel_x == '0) && (o_out.vel_y == '0), "nonzero velocity at zero depth")
    `LBM_ASSERT_IMP(a_div_align, i_clk, i_rst_n, dx_vld, dy_vld, "velocity dividers out of step")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the D2Q9 shallow-water collision kernel.
`timescale 1ns / 100ps

module tb_top;
    import lbm_swe_pkg::*;

    // Clock, reset and the ports of the kernel.
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_in;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic        o_valid;
    t_out        o_out;

    lbm_d2q9_swe_collision i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

    // The pause before a register write and at the end of the run outlasts the kernel's latency.
    localparam int DRAIN_CYCLES = 120;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;

    // Shadow copies of the three configuration registers.
    longint speed_reg;
    longint relax_reg;
    longint scale_reg;

    t_in    cell_q[$];       // Cells waiting to be presented on the input.
    t_out   collided_q[$];   // Predicted results of the accepted active cells.
    int     error_count;
    int     quiet_cycles;
    bit     took;
    bit     gaps_on;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Saturation and fixed-point arithmetic of the kernel, all carried in 64 bits.
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 product: exact product, arithmetic shift (floor), then saturation.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> 16);
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint fx_sub(input longint a, input longint b);
        return clamp32(a - b);
    endfunction

    // Equilibrium of one moving direction: weight * (gh + v + 4.5 s^2 k - usq).
    function automatic longint dir_equilibrium(input longint weight, input longint gh,
                                               input longint v, input longint s,
                                               input longint usq);
        longint sq;
        longint inner;
        sq    = fx_mul(fx_mul(fx_mul(longint'(C_4P5), s), s), scale_reg);
        inner = fx_sub(fx_add(fx_add(gh, v), sq), usq);
        return fx_mul(weight, inner);
    endfunction

    // Full collision of one active cell under the current register settings.
    function automatic t_out collide_cell(input t_in c);
        longint f[9];
        longint feq[9];
        longint post[9];
        longint h, mx, my, ux, uy, gh, usq, ux3, uy3, d5, d6, hk, hkq;
        t_out   r;
        f[0] = $signed(c.dist_rest);
        f[1] = $signed(c.dist_east);
        f[2] = $signed(c.dist_north);
        f[3] = $signed(c.dist_west);
        f[4] = $signed(c.dist_south);
        f[5] = $signed(c.dist_northeast);
        f[6] = $signed(c.dist_northwest);
        f[7] = $signed(c.dist_southwest);
        f[8] = $signed(c.dist_southeast);
        h  = clamp32(f[0] + f[1] + f[2] + f[3] + f[4] + f[5] + f[6] + f[7] + f[8]);
        mx = clamp32(f[1] - f[3] + f[5] - f[6] - f[7] + f[8]);
        my = clamp32(f[2] - f[4] + f[5] + f[6] - f[7] - f[8]);
        ux = 0;
        uy = 0;
        // A dry cell keeps zero velocity; otherwise the quotient truncates toward zero.
        if (h != 0) begin
            ux = clamp32((speed_reg * mx) / h);
            uy = clamp32((speed_reg * my) / h);
        end
        gh  = fx_mul(longint'(C_GH), h);
        usq = fx_mul(longint'(C_1P5), fx_add(fx_mul(ux, ux), fx_mul(uy, uy)));
        ux3 = fx_mul(longint'(C_3), fx_mul(speed_reg, ux));
        uy3 = fx_mul(longint'(C_3), fx_mul(speed_reg, uy));
        d5  = fx_add(ux3, uy3);
        d6  = fx_sub(uy3, ux3);
        hk  = fx_mul(h, scale_reg);
        hkq = fx_mul(hk, longint'(C_QUARTER));
        feq[0] = fx_mul(h, fx_sub(longint'(C_ONE), fx_mul(scale_reg,
                 fx_add(fx_mul(longint'(C_5), gh), fx_mul(longint'(C_4), usq)))));
        feq[1] = dir_equilibrium(hk, gh, ux3, ux3, usq);
        feq[2] = dir_equilibrium(hk, gh, uy3, uy3, usq);
        feq[3] = dir_equilibrium(hk, gh, fx_sub(0, ux3), ux3, usq);
        feq[4] = dir_equilibrium(hk, gh, fx_sub(0, uy3), uy3, usq);
        feq[5] = dir_equilibrium(hkq, gh, d5, d5, usq);
        feq[6] = dir_equilibrium(hkq, gh, d6, d6, usq);
        feq[7] = dir_equilibrium(hkq, gh, fx_sub(0, d5), d5, usq);
        feq[8] = dir_equilibrium(hkq, gh, fx_sub(0, d6), d6, usq);
        for (int j = 0; j < 9; j++) begin
            post[j] = fx_sub(f[j], fx_mul(fx_sub(f[j], feq[j]), relax_reg));
        end
        r.post_rest      = post[0][31:0];
        r.post_east      = post[1][31:0];
        r.post_north     = post[2][31:0];
        r.post_west      = post[3][31:0];
        r.post_south     = post[4][31:0];
        r.post_northeast = post[5][31:0];
        r.post_northwest = post[6][31:0];
        r.post_southwest = post[7][31:0];
        r.post_southeast = post[8][31:0];
        r.depth          = h[31:0];
        r.vel_x          = ux[31:0];
        r.vel_y          = uy[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Register writes happen only while no cell is in flight.
    task automatic write_reg(input t_cfg_idx idx, input longint value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        case (idx)
            CFG_LATTICE_SPEED: speed_reg = value & 64'h7FFFFFFF;
            CFG_RELAX_INVERSE: relax_reg = value & 64'h7FFFFFFF;
            CFG_EQ_SCALE:      scale_reg = value & 64'h7FFFFFFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One distribution value; the kind picks plausible water, small signed, wide or edge values.
    function automatic logic [31:0] pick_dist(input int kind);
        case (kind)
            0: return $urandom_range(32'h00020000, 32'h00000000);
            1: return 32'($signed($urandom_range(16'hFFFF)) - 32768);
            2: return $urandom_range(3) == 0 ? 32'h7FFFFFFF :
                      ($urandom_range(1) ? 32'h80000000 : 32'h00000000);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in random_cell(input int kind);
        t_in c;
        c.cell_active    = ($urandom_range(99) < 88);
        c.dist_rest      = pick_dist(kind);
        c.dist_east      = pick_dist(kind);
        c.dist_north     = pick_dist(kind);
        c.dist_west      = pick_dist(kind);
        c.dist_south     = pick_dist(kind);
        c.dist_northeast = pick_dist(kind);
        c.dist_northwest = pick_dist(kind);
        c.dist_southwest = pick_dist(kind);
        c.dist_southeast = pick_dist(kind);
        return c;
    endfunction

    task automatic queue_random(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            // Mostly realistic cells, then small signed values, saturation corners, full range.
            cell_q.push_back(random_cell(r < 50 ? 0 : (r < 70 ? 1 : (r < 80 ? 2 : 3))));
        end
    endtask

    // Wait for every queued cell to be taken and every prediction to be matched,
    // then for the pipeline to empty of inactive cells as well.
    task automatic drain;
        while (cell_q.size() != 0 || start || collided_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_directed;
        t_in c;
        c = '0;
        c.cell_active = 1'b1;
        cell_q.push_back(c);                        // still, dry cell
        c.dist_rest = 32'sd65536;
        cell_q.push_back(c);                        // water at rest, depth 1.0
        c.cell_active = 1'b0;
        cell_q.push_back(c);                        // inactive cell is dropped
        c = '0;
        c.cell_active = 1'b1;
        c.dist_east = 32'sd40000;
        c.dist_west = -32'sd40000;
        cell_q.push_back(c);                        // zero depth but nonzero x moment
        c = '0;
        c.cell_active = 1'b1;
        c.dist_north = 32'sd70000;
        c.dist_south = -32'sd70000;
        c.dist_northeast = 32'sd3;
        c.dist_southwest = -32'sd3;
        cell_q.push_back(c);                        // zero depth, diagonal moment too
        for (int j = 0; j < 9; j++) begin
            c = '0;
            c.cell_active = 1'b1;
            c.dist_rest = 32'sd65536;
            c[(8 - j) * 32 +: 32] = 32'sd30000;     // one direction dominating
            cell_q.push_back(c);
        end
        c = '1;
        c.dist_rest = 32'h7FFFFFFF; c.dist_east = 32'h7FFFFFFF; c.dist_north = 32'h7FFFFFFF;
        c.dist_west = 32'h7FFFFFFF; c.dist_south = 32'h7FFFFFFF;
        c.dist_northeast = 32'h7FFFFFFF; c.dist_northwest = 32'h7FFFFFFF;
        c.dist_southwest = 32'h7FFFFFFF; c.dist_southeast = 32'h7FFFFFFF;
        cell_q.push_back(c);                        // depth sum saturates high, moments cancel
        c.dist_rest = 32'h80000000; c.dist_east = 32'h80000000; c.dist_north = 32'h80000000;
        c.dist_west = 32'h80000000; c.dist_south = 32'h80000000;
        c.dist_northeast = 32'h80000000; c.dist_northwest = 32'h80000000;
        c.dist_southwest = 32'h80000000; c.dist_southeast = 32'h80000000;
        cell_q.push_back(c);                        // depth sum saturates low, moments cancel
        c = '0;
        c.cell_active = 1'b1;
        c.dist_rest = 32'sd1;
        c.dist_east = 32'h7FFFFFFF;
        c.dist_west = 32'h80000001;
        cell_q.push_back(c);                        // tiny depth, huge velocity
        c = '0;
        c.cell_active = 1'b1;
        c.dist_rest = -32'sd65536;
        c.dist_northwest = 32'sd20000;
        cell_q.push_back(c);                        // negative depth
        c = '1;
        cell_q.push_back(c);                        // all bits set, depth -9 ulp
    endtask

    // Driver: a new cell (or a gap) is chosen once the current one has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!start || took) begin
                if (cell_q.size() != 0 && !(gaps_on && $urandom_range(99) < 8)) begin
                    i_in  <= cell_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: predicts at each input transfer, checks each result transfer, and
    // ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            took = start && !busy;
            if (took && i_in.cell_active) begin
                collided_q.push_back(collide_cell(i_in));
            end
            if (o_valid) begin
                if (collided_q.size() == 0) begin
                    $display("%0t: result with no cell outstanding", $realtime);
                    error_count++;
                end else begin
                    want = collided_q.pop_front();
                    if (o_out.post_rest != want.post_rest)
                        report_mismatch("post_rest", o_out.post_rest, want.post_rest);
                    if (o_out.post_east != want.post_east)
                        report_mismatch("post_east", o_out.post_east, want.post_east);
                    if (o_out.post_north != want.post_north)
                        report_mismatch("post_north", o_out.post_north, want.post_north);
                    if (o_out.post_west != want.post_west)
                        report_mismatch("post_west", o_out.post_west, want.post_west);
                    if (o_out.post_south != want.post_south)
                        report_mismatch("post_south", o_out.post_south, want.post_south);
                    if (o_out.post_northeast != want.post_northeast)
                        report_mismatch("post_northeast", o_out.post_northeast,
                                        want.post_northeast);
                    if (o_out.post_northwest != want.post_northwest)
                        report_mismatch("post_northwest", o_out.post_northwest,
                                        want.post_northwest);
                    if (o_out.post_southwest != want.post_southwest)
                        report_mismatch("post_southwest", o_out.post_southwest,
                                        want.post_southwest);
                    if (o_out.post_southeast != want.post_southeast)
                        report_mismatch("post_southeast", o_out.post_southeast,
                                        want.post_southeast);
                    if (o_out.depth != want.depth)
                        report_mismatch("depth", o_out.depth, want.depth);
                    if (o_out.vel_x != want.vel_x)
                        report_mismatch("vel_x", o_out.vel_x, want.vel_x);
                    if (o_out.vel_y != want.vel_y)
                        report_mismatch("vel_y", o_out.vel_y, want.vel_y);
                end
            end
            if (took || o_valid) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("lbm_d2q9_swe_collision: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_in         = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_LATTICE_SPEED;
        i_cfg_data   = '0;
        took         = 1'b0;
        gaps_on      = 1'b1;
        error_count  = 0;
        quiet_cycles = 0;
        speed_reg    = longint'(RST_LATTICE_SPEED);
        relax_reg    = longint'(RST_RELAX_INVERSE);
        scale_reg    = longint'(RST_EQ_SCALE);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: directed cells, then random ones.
        queue_directed();
        queue_random(230);
        drain();

        // Lattice speed 2.0, tau 2.0, matching scale 1/36; no gaps at all here.
        write_reg(CFG_LATTICE_SPEED, 131072);
        write_reg(CFG_RELAX_INVERSE, 32768);
        write_reg(CFG_EQ_SCALE, 1820);
        gaps_on = 1'b0;
        queue_directed();
        queue_random(230);
        drain();
        gaps_on = 1'b1;

        // No relaxation at all: results keep the incoming distributions.
        write_reg(CFG_RELAX_INVERSE, 0);
        write_reg(CFG_EQ_SCALE, 0);
        queue_random(230);
        drain();

        // Every register at its largest value.
        write_reg(CFG_LATTICE_SPEED, 64'h7FFFFFFF);
        write_reg(CFG_RELAX_INVERSE, 64'h7FFFFFFF);
        write_reg(CFG_EQ_SCALE, 64'h7FFFFFFF);
        queue_directed();
        queue_random(230);
        drain();

        // Smallest speed, and a zero speed that forces still water.
        write_reg(CFG_LATTICE_SPEED, 1);
        write_reg(CFG_RELAX_INVERSE, 65536);
        write_reg(CFG_EQ_SCALE, 7282);
        queue_random(120);
        drain();
        write_reg(CFG_LATTICE_SPEED, 0);
        queue_random(120);
        drain();

        // Random settings.
        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_LATTICE_SPEED, $urandom_range(32'h00040000, 1));
            write_reg(CFG_RELAX_INVERSE, $urandom_range(32'h00020000, 0));
            write_reg(CFG_EQ_SCALE, $urandom() & 32'h7FFFFFFF);
            queue_random(130);
            drain();
        end

        if (error_count == 0) begin
            $display("lbm_d2q9_swe_collision: match");
        end else begin
            $display("lbm_d2q9_swe_collision: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lbm_swe_pkg.sv
src/lbm_swe_div.sv
src/lbm_d2q9_swe_collision.sv
test/tb_top.sv
